/* rtl/mstt_pkg.sv */
// shared types, codes and defaults for the multi-slot timeout table
package mstt_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int TICK_BITS_DEF = 32;
   localparam int TAG_BITS_DEF  = 16;

   // command codes
   localparam logic [1:0] CMD_CREATE  = 2'd0;
   localparam logic [1:0] CMD_DELETE  = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_PROCESS = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_NOT_USED = 3'd2;
   localparam logic [2:0] ST_FIRED    = 3'd3;
   localparam logic [2:0] ST_NONE_DUE = 3'd4;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] now;
      logic [31:0] timeout;
      logic        periodic;
      logic [2:0]  slot;
      logic [15:0] tag;
   } mstt_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot_res;
      logic [15:0] tag_res;
      logic        last;
   } mstt_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic single_step;
      logic create_step;
      logic proc_issue;
      logic proc_finish;
   } mstt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic create_done;
      logic idx_last;
      logic pipe_busy;
   } mstt_stat_type;

endpackage

/* rtl/mstt_ctrl.sv */
// command sequencer of the timeout table
module mstt_ctrl
   import mstt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_command,
   input  mstt_stat_type stat,
   output mstt_cmd_type  cmd,
   output logic          busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SINGLE = 3'd1;
   localparam logic [2:0] S_CREATE = 3'd2;
   localparam logic [2:0] S_PROC   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_command)
                  CMD_CREATE:  state_in = S_CREATE;
                  CMD_DELETE:  state_in = S_SINGLE;
                  CMD_RESTART: state_in = S_SINGLE;
                  default:     state_in = S_PROC;
               endcase
            end
         end
         S_SINGLE: begin
            cmd.single_step = 1'b1;
            state_in        = S_IDLE;
         end
         S_CREATE: begin
            cmd.create_step = 1'b1;
            if (stat.create_done) begin
               state_in = S_IDLE;
            end
         end
         S_PROC: begin
            cmd.proc_issue = 1'b1;
            if (stat.idx_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) begin
               cmd.proc_finish = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* rtl/mstt_dp.sv */
// slot storage, elapsed-time pipeline and result register
module mstt_dp
   import mstt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int TICK_BITS = TICK_BITS_DEF,
   parameter int TAG_BITS  = TAG_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  mstt_req_type  req_data,
   input  logic          csr_write,
   input  logic [31:0]   csr_data,
   input  mstt_cmd_type  cmd,
   output mstt_stat_type stat,
   output logic          rsp_valid,
   output mstt_rsp_type  rsp_data
);

   localparam int          SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [31:0] SLOTS_32    = 32'(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

   // captured request
   mstt_req_type req_ff;

   // tick_max + 1, kept ready for the wrap correction
   logic [TICK_BITS-1:0] tmax_p1_ff;
   logic [TICK_BITS-1:0] tmax_p1_in;
   logic [TICK_BITS+31:0] csr_wide;

   logic [NUM_SLOTS-1:0] in_use_ff;
   logic [NUM_SLOTS-1:0] in_use_in;
   logic [SLOT_W-1:0]    idx_ff;
   logic [SLOT_W-1:0]    idx_in;

   // slot memories
   logic [TICK_BITS-1:0] start_mem [NUM_SLOTS];
   logic [TICK_BITS-1:0] tmo_mem   [NUM_SLOTS];
   logic                 mode_mem  [NUM_SLOTS];
   logic [TAG_BITS-1:0]  tag_mem   [NUM_SLOTS];

   logic                 start_we;
   logic [SLOT_W-1:0]    start_wa;
   logic                 create_we;

   // read stage
   logic                 s1_valid_ff;
   logic [SLOT_W-1:0]    s1_idx_ff;
   logic [TICK_BITS-1:0] start_rd_ff;
   logic [TICK_BITS-1:0] tmo_rd_ff;
   logic                 mode_rd_ff;
   logic [TAG_BITS-1:0]  tag_rd_ff;

   // elapsed stage
   logic                 s2_valid_ff;
   logic [SLOT_W-1:0]    s2_idx_ff;
   logic [TICK_BITS-1:0] s2_elapsed_ff;
   logic [TICK_BITS-1:0] s2_tmo_ff;
   logic                 s2_mode_ff;
   logic [TAG_BITS-1:0]  s2_tag_ff;

   // fired result held back until the next one or the end of the scan
   logic        pend_valid_ff;
   logic        pend_valid_in;
   logic [2:0]  pend_slot_ff;
   logic [15:0] pend_tag_ff;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   mstt_rsp_type rsp_ff;
   mstt_rsp_type rsp_in;

   // field conversions
   logic [TICK_BITS+31:0] now_wide;
   logic [TICK_BITS+31:0] tmo_wide;
   logic [TAG_BITS+15:0]  tag_wide;
   logic [TICK_BITS-1:0]  now_t;
   logic [TICK_BITS-1:0]  tmo_t;
   logic [TAG_BITS-1:0]   tag_t;
   logic [SLOT_W+2:0]     slot_wide;
   logic [SLOT_W-1:0]     slot_idx;
   logic                  slot_used;
   logic [SLOT_W+2:0]     idx_wide;
   logic [SLOT_W+2:0]     s2_idx_wide;
   logic [TAG_BITS+15:0]  s2_tag_wide;

   logic                 slot_free;
   logic [TICK_BITS:0]   diff;
   logic [TICK_BITS-1:0] elapsed;
   logic                 fire;

   assign now_wide   = {{TICK_BITS{1'b0}}, req_ff.now};
   assign tmo_wide   = {{TICK_BITS{1'b0}}, req_ff.timeout};
   assign tag_wide   = {{TAG_BITS{1'b0}}, req_ff.tag};
   assign now_t      = now_wide[TICK_BITS-1:0];
   assign tmo_t      = tmo_wide[TICK_BITS-1:0];
   assign tag_t      = tag_wide[TAG_BITS-1:0];
   assign slot_wide  = {{SLOT_W{1'b0}}, req_ff.slot};
   assign slot_idx   = slot_wide[SLOT_W-1:0];
   assign slot_used  = ({29'd0, req_ff.slot} < SLOTS_32) && in_use_ff[slot_idx];
   assign idx_wide   = {3'd0, idx_ff};
   assign s2_idx_wide = {3'd0, s2_idx_ff};
   assign s2_tag_wide = {16'd0, s2_tag_ff};

   assign csr_wide   = {{TICK_BITS{1'b0}}, csr_data};
   assign tmax_p1_in = csr_wide[TICK_BITS-1:0] + TICK_BITS'(1);

   assign slot_free  = !in_use_ff[idx_ff];
   assign create_we  = cmd.create_step && slot_free;

   // wrapped elapsed time is the plain difference plus tick_max + 1
   assign diff    = {1'b0, now_t} - {1'b0, start_rd_ff};
   assign elapsed = diff[TICK_BITS-1:0] + (diff[TICK_BITS] ? tmax_p1_ff : '0);

   assign fire = s2_valid_ff && (s2_elapsed_ff >= s2_tmo_ff);

   assign stat.create_done = slot_free || (idx_ff == LAST_IDX);
   assign stat.idx_last    = (idx_ff == LAST_IDX);
   assign stat.pipe_busy   = s1_valid_ff || s2_valid_ff;

   // start memory has one write port shared by create, restart and refresh
   always_comb begin
      start_we = 1'b0;
      start_wa = idx_ff;
      if (create_we) begin
         start_we = 1'b1;
      end else if (cmd.single_step && slot_used && req_ff.command == CMD_RESTART) begin
         start_we = 1'b1;
         start_wa = slot_idx;
      end else if (fire && s2_mode_ff) begin
         start_we = 1'b1;
         start_wa = s2_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[start_wa] <= now_t;
      end
      if (create_we) begin
         tmo_mem[idx_ff]  <= tmo_t;
         mode_mem[idx_ff] <= req_ff.periodic;
         tag_mem[idx_ff]  <= tag_t;
      end
      start_rd_ff <= start_mem[idx_ff];
      tmo_rd_ff   <= tmo_mem[idx_ff];
      mode_rd_ff  <= mode_mem[idx_ff];
      tag_rd_ff   <= tag_mem[idx_ff];
   end

   // slot index counter
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.create_step || cmd.proc_issue) begin
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      in_use_in = in_use_ff;
      if (create_we) begin
         in_use_in[idx_ff] = 1'b1;
      end
      if (cmd.single_step && slot_used && req_ff.command == CMD_DELETE) begin
         in_use_in[slot_idx] = 1'b0;
      end
      if (fire && !s2_mode_ff) begin
         in_use_in[s2_idx_ff] = 1'b0;
      end
   end

   // result selection
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      pend_valid_in = pend_valid_ff;
      if (cmd.single_step) begin
         rsp_valid_in    = 1'b1;
         rsp_in.status   = slot_used ? ST_OK : ST_NOT_USED;
         rsp_in.slot_res = req_ff.slot;
         rsp_in.last     = 1'b1;
      end else if (cmd.create_step && stat.create_done) begin
         rsp_valid_in    = 1'b1;
         rsp_in.status   = slot_free ? ST_OK : ST_FULL;
         rsp_in.slot_res = slot_free ? idx_wide[2:0] : 3'd0;
         rsp_in.last     = 1'b1;
      end else if (fire) begin
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_valid_in    = 1'b1;
            rsp_in.status   = ST_FIRED;
            rsp_in.slot_res = pend_slot_ff;
            rsp_in.tag_res  = pend_tag_ff;
         end
      end else if (cmd.proc_finish) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_in.last   = 1'b1;
         if (pend_valid_ff) begin
            rsp_in.status   = ST_FIRED;
            rsp_in.slot_res = pend_slot_ff;
            rsp_in.tag_res  = pend_tag_ff;
         end else begin
            rsp_in.status = ST_NONE_DUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmax_p1_ff    <= TICK_BITS'(({{TICK_BITS{1'b0}}, 32'hFFFF_FFFF} + 1));
         in_use_ff     <= '0;
         idx_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            tmax_p1_ff <= tmax_p1_in;
         end
         in_use_ff     <= in_use_in;
         idx_ff        <= idx_in;
         s1_valid_ff   <= cmd.proc_issue && in_use_ff[idx_ff];
         s2_valid_ff   <= s1_valid_ff;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      s1_idx_ff     <= idx_ff;
      s2_idx_ff     <= s1_idx_ff;
      s2_elapsed_ff <= elapsed;
      s2_tmo_ff     <= tmo_rd_ff;
      s2_mode_ff    <= mode_rd_ff;
      s2_tag_ff     <= tag_rd_ff;
      if (fire) begin
         pend_slot_ff <= s2_idx_wide[2:0];
         pend_tag_ff  <= s2_tag_wide[15:0];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/multi_slot_timeout_table_top.sv */
// top level of the multi-slot timeout table
//
//  channel | ports                          | transfer when
//  --------+--------------------------------+------------------------------
//  request | start, busy, req_data          | start high, busy low
//  result  | rsp_valid, rsp_data            | every cycle rsp_valid is high
//  config  | csr_valid, csr_ready, csr_data | csr_valid and csr_ready high
//
//  delete and restart: a single busy state, one result the cycle after it
//  create: the free-slot search walks the in-use flags one slot a cycle
//    from slot 0 and stops at the first free one
//  process: one slot enters the read / elapsed / compare pipeline each
//    cycle, then the table waits until the pipeline has drained, which
//    depends on whether the last two slots are in use
//  results leave through an output register the cycle after they are
//    decided; the receiver cannot stall, so nothing ever backs up
//  reset (synchronous) frees every slot and sets tick_max to all ones;
//    slot contents are left as they are
module multi_slot_timeout_table_top
   import mstt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int TICK_BITS = TICK_BITS_DEF,
   parameter int TAG_BITS  = TAG_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         start,
   output logic         busy,
   input  mstt_req_type req_data,
   // result channel
   output logic         rsp_valid,
   output mstt_rsp_type rsp_data,
   // tick_max register
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   mstt_cmd_type  cmd;
   mstt_stat_type stat;

   // sequencer: picks the command path and steps the slot scan
   mstt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_data.command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   // config only lands while the table is idle
   assign csr_ready = !busy;

   // slot store, elapsed-time pipeline and result register
   mstt_dp #(
      .NUM_SLOTS (NUM_SLOTS),
      .TICK_BITS (TICK_BITS),
      .TAG_BITS  (TAG_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/mstt_checker.sv */
// port-level checks on the timeout table, bound to the top level
module mstt_checker
   import mstt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input mstt_rsp_type rsp_data
);

   // reset leaves the table idle with no result showing
   assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("table not idle after reset");

   // an accepted request keeps the table busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request transfer did not raise busy");

   // only fired results carry a tag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_FIRED |-> rsp_data.tag_res == 16'd0)
      else $error("tag on a result that did not fire");

   // nothing-due is a lone closing result on slot zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_NONE_DUE |-> rsp_data.last
         && rsp_data.slot_res == 3'd0)
      else $error("malformed nothing-due result");

   // more results of the same request are still to come
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("non-final result while idle");

endmodule

bind multi_slot_timeout_table_top mstt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
